[hw/rtl/rev_pkg.sv]
// Shared types, constants and arithmetic helpers of the rotated ellipse vertex generator.
package rev_pkg;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_QUAD_VERTS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_MODE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_SHADE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_LOW  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_HIGH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTLINE    = 3'd5;

	localparam logic [1:0] FILL_NONE  = 2'd0;
	localparam logic [1:0] FILL_INPUT = 2'd1;
	localparam logic [1:0] FILL_CONST = 2'd2;

	// defaults of the top level parameters
	localparam int unsigned MAX_QV_DEF     = 15;
	localparam int unsigned ANGLE_BITS_DEF = 16;

	// field widths
	localparam int unsigned QV_W        = 4;
	localparam int unsigned VNUM_W      = QV_W + 2;
	localparam int unsigned COORD_W     = 32;
	localparam int unsigned SHADE_W     = 16;
	localparam int unsigned COLOR_W     = 8;
	localparam int unsigned IN_TDATA_W  = 160;
	localparam int unsigned OUT_TDATA_W = 80;
	localparam int unsigned OUT_TUSER_W = 4;

	// arithmetic formats
	localparam int unsigned TRIG_FRAC     = 16;
	localparam int unsigned TRIG_W        = 18;
	localparam int unsigned CORDIC_W      = 34;
	localparam int unsigned CORDIC_FRAC   = 30;
	localparam int unsigned CORDIC_STEPS  = 20;
	localparam int unsigned CORDIC_STEP_W = 5;
	localparam int unsigned TERM_W        = COORD_W + 1;
	localparam int unsigned PROD_W        = TERM_W + TRIG_W;
	localparam int unsigned ACC_W         = PROD_W + 2;
	localparam int unsigned SAT_W         = ACC_W - TRIG_FRAC;

	localparam logic signed [CORDIC_W-1:0] CORDIC_X_INIT = 34'sd652032874;
	localparam logic signed [CORDIC_W-1:0] TRIG_POS      = 34'sd65536;
	localparam logic signed [CORDIC_W-1:0] TRIG_NEG      = -34'sd65536;

	localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W-31){1'b1}}, {31{1'b0}}};

	typedef enum logic [2:0] {
		MAC_NONE,
		MAC_MUL,
		MAC_LOAD,
		MAC_ADD,
		MAC_SUB
	} mac_op_t;

	typedef struct packed {
		mac_op_t                   op;
		logic signed [TERM_W-1:0]  a;
		logic signed [TRIG_W-1:0]  b;
		logic signed [ACC_W-1:0]   bias;
	} mac_req_t;

	typedef struct packed {
		logic        start;
		logic [31:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [TRIG_W-1:0]  cos_v;
		logic signed [TRIG_W-1:0]  sin_v;
	} cordic_rsp_t;

	// arctangent of 2^-i as a 32-bit binary angle
	function automatic logic [CORDIC_FRAC-1:0] rev_atan(input logic [CORDIC_STEP_W-1:0] i);
		logic [CORDIC_FRAC-1:0] r;
		case (i)
			5'd0:    r = 30'h20000000;
			5'd1:    r = 30'h12E4051E;
			5'd2:    r = 30'h09FB385B;
			5'd3:    r = 30'h051111D4;
			5'd4:    r = 30'h028B0D43;
			5'd5:    r = 30'h0145D7E1;
			5'd6:    r = 30'h00A2F61E;
			5'd7:    r = 30'h00517C55;
			5'd8:    r = 30'h0028BE53;
			5'd9:    r = 30'h00145F2F;
			5'd10:   r = 30'h000A2F98;
			5'd11:   r = 30'h000517CC;
			5'd12:   r = 30'h00028BE6;
			5'd13:   r = 30'h000145F3;
			5'd14:   r = 30'h0000A2FA;
			5'd15:   r = 30'h0000517D;
			5'd16:   r = 30'h000028BE;
			5'd17:   r = 30'h0000145F;
			5'd18:   r = 30'h00000A30;
			5'd19:   r = 30'h00000518;
			default: r = '0;
		endcase
		return r;
	endfunction

	// product of a Q16.16 value and a Q2.16 trig value, rounded half up to Q16.16
	function automatic logic signed [TERM_W-1:0] rev_round_term(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + $signed({{(PROD_W-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}});
		return $signed(t[TRIG_FRAC+TERM_W-1:TRIG_FRAC]);
	endfunction

	// drop the fraction of a biased sum and saturate to a 32-bit coordinate
	function automatic logic [COORD_W-1:0] rev_sat_coord(input logic signed [ACC_W-1:0] acc);
		logic signed [SAT_W-1:0] s;
		logic [COORD_W-1:0]      r;
		s = $signed(acc[ACC_W-1:TRIG_FRAC]);
		if (s > SAT_HI) begin
			r = SAT_HI[COORD_W-1:0];
		end else if (s < SAT_LO) begin
			r = SAT_LO[COORD_W-1:0];
		end else begin
			r = s[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/rev_cordic.sv]
// Iterative CORDIC unit: sine and cosine of a 32-bit binary angle in Q2.16, one step per cycle.
module rev_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rev_pkg::cordic_req_t req,
	output rev_pkg::cordic_rsp_t rsp
);
	import rev_pkg::*;

	typedef enum logic [1:0] {
		C_IDLE,
		C_RUN,
		C_ROUND,
		C_MAP
	} cstate_t;

	cstate_t                    state_q;
	logic [CORDIC_STEP_W-1:0]   step_q;
	logic [1:0]                 quad_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [CORDIC_W-1:0] z_q;
	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;
	logic signed [CORDIC_W-1:0] atan_v;
	logic signed [CORDIC_W-1:0] x_rnd;
	logic signed [CORDIC_W-1:0] y_rnd;
	logic signed [TRIG_W-1:0]   cr_q;
	logic signed [TRIG_W-1:0]   sr_q;
	logic signed [TRIG_W-1:0]   cos_q;
	logic signed [TRIG_W-1:0]   sin_q;
	logic                       done_q;

	function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [CORDIC_W-1:0] v);
		logic signed [TRIG_W-1:0] r;
		if (v > TRIG_POS) begin
			r = TRIG_POS[TRIG_W-1:0];
		end else if (v < TRIG_NEG) begin
			r = TRIG_NEG[TRIG_W-1:0];
		end else begin
			r = v[TRIG_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		dx     = y_q >>> step_q;
		dy     = x_q >>> step_q;
		atan_v = $signed({{(CORDIC_W-CORDIC_FRAC){1'b0}}, rev_atan(step_q)});
		// round half up to Q2.16
		x_rnd  = (x_q + $signed(CORDIC_W'(1) << (CORDIC_FRAC-TRIG_FRAC-1)))
			>>> (CORDIC_FRAC-TRIG_FRAC);
		y_rnd  = (y_q + $signed(CORDIC_W'(1) << (CORDIC_FRAC-TRIG_FRAC-1)))
			>>> (CORDIC_FRAC-TRIG_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			quad_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			cr_q    <= '0;
			sr_q    <= '0;
			cos_q   <= '0;
			sin_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (req.start) begin
						x_q     <= CORDIC_X_INIT;
						y_q     <= '0;
						z_q     <= $signed({{(CORDIC_W-CORDIC_FRAC){1'b0}},
							req.angle[CORDIC_FRAC-1:0]});
						quad_q  <= req.angle[31:30];
						step_q  <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (!z_q[CORDIC_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_v;
					end
					step_q <= step_q + 1'b1;
					if (step_q == CORDIC_STEP_W'(CORDIC_STEPS-1)) begin
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					cr_q    <= clamp_trig(x_rnd);
					sr_q    <= clamp_trig(y_rnd);
					state_q <= C_MAP;
				end
				C_MAP: begin
					// fold the first quadrant result out to the full turn
					case (quad_q)
						2'd0: begin
							cos_q <= cr_q;
							sin_q <= sr_q;
						end
						2'd1: begin
							cos_q <= -sr_q;
							sin_q <= cr_q;
						end
						2'd2: begin
							cos_q <= -cr_q;
							sin_q <= -sr_q;
						end
						default: begin
							cos_q <= sr_q;
							sin_q <= -cr_q;
						end
					endcase
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = cos_q;
	assign rsp.sin_v = sin_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == C_IDLE)
		else $error("cordic started while busy");

	a_done_after_map: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == C_MAP && state_q == C_IDLE)
		else $error("cordic done without finishing the quadrant map");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_RUN |-> step_q < CORDIC_STEP_W'(CORDIC_STEPS))
		else $error("cordic step counter ran past the last step");

endmodule

[hw/rtl/rev_mac.sv]
// Shared multiplier with a registered product and a biased accumulator.
module rev_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rev_pkg::mac_req_t                      req,
	output logic signed [rev_pkg::PROD_W-1:0]      prod_s1,
	output logic signed [rev_pkg::ACC_W-1:0]       acc_q
);
	import rev_pkg::*;

	mac_op_t                 op_s1;
	logic signed [ACC_W-1:0] bias_s1;
	logic signed [ACC_W-1:0] prod_ext;

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= MAC_NONE;
		end else begin
			op_s1 <= req.op;
		end
	end

	always_ff @(posedge clk) begin
		if (req.op != MAC_NONE) begin
			prod_s1 <= $signed(req.a) * $signed(req.b);
			bias_s1 <= req.bias;
		end
		case (op_s1)
			MAC_LOAD: acc_q <= bias_s1 + prod_ext;
			MAC_ADD:  acc_q <= acc_q + prod_ext;
			MAC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
	end

endmodule

[hw/rtl/rotated_ellipse_vertex_generator_top.sv]
// Top level of the rotated ellipse vertex generator: sequencer, registers and stream ports.
//
// Each accepted ellipse produces 4*N+1 vertices (N = quadrant_vertices, clamped to
// 1..MAX_QUADRANT_VERTICES), the last one repeating the first to close the outline.
// All trig goes through one 20-step CORDIC unit and all products through one shared
// 33x18 multiplier, so the block works on one ellipse at a time and s_axis_tready is
// high only between ellipses. An ellipse starts with the rotation trig and the fill
// index, then each vertex takes a CORDIC pass for the vertex angle, six multiplies
// and two sums. The output register lets the next ellipse be accepted while the
// closing vertex of the one before still waits on m_axis_tready.
module rotated_ellipse_vertex_generator_top #(
	parameter int unsigned MAX_QUADRANT_VERTICES = rev_pkg::MAX_QV_DEF,
	parameter int unsigned ANGLE_BITS            = rev_pkg::ANGLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rev_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rev_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// centre_x, centre_y, axis_major, axis_minor, position_angle, shade
	input  logic [rev_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// final_ellipse
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// vertex_x, vertex_y, vertex_number, fill_index, zero pad
	output logic [rev_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// last
	output logic                                m_axis_tlast,
	// closing_vertex, fill_enable, outline_enable, set_end
	output logic [rev_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
	import rev_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROT_WAIT,
		S_FILL_MUL,
		S_FILL_IDX,
		S_V_START,
		S_V_WAIT,
		S_MUL_A,
		S_MUL_B,
		S_MUL_XC,
		S_MUL_YS,
		S_MUL_XS,
		S_MUL_YC,
		S_SUM_WAIT,
		S_SUM_Y,
		S_EMIT
	} state_t;

	localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	// configuration
	logic [QV_W-1:0]    quad_q;
	logic [1:0]         fill_mode_q;
	logic [SHADE_W-1:0] fill_shade_q;
	logic [COLOR_W-1:0] color_low_q;
	logic [COLOR_W-1:0] color_high_q;
	logic               draw_outline_q;

	// ellipse in work
	state_t                     state_q;
	logic signed [COORD_W-1:0]  cx_q;
	logic signed [COORD_W-1:0]  cy_q;
	logic signed [COORD_W-1:0]  ax_q;
	logic signed [COORD_W-1:0]  bx_q;
	logic [SHADE_W-1:0]         shade_q;
	logic                       final_q;
	logic signed [TRIG_W-1:0]   rot_cos_q;
	logic signed [TRIG_W-1:0]   rot_sin_q;
	logic                       fill_en_q;
	logic [COLOR_W-1:0]         fill_idx_q;
	logic [ANGLE_BITS-1:0]      theta_q;
	logic [QV_W-1:0]            rem_q;
	logic [VNUM_W-1:0]          v_q;
	logic signed [TERM_W-1:0]   x_term_q;
	logic signed [TERM_W-1:0]   y_term_q;
	logic [COORD_W-1:0]         vx_q;
	logic [COORD_W-1:0]         vy_q;

	// output register
	logic               m_valid_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [VNUM_W-1:0]  out_num_q;
	logic               out_last_q;
	logic               out_fill_en_q;
	logic [COLOR_W-1:0] out_fill_idx_q;
	logic               out_outline_q;
	logic               out_set_end_q;

	// angle step tables, indexed by the vertex count per quadrant
	logic [ANGLE_BITS-1:0] step_quo [1:MAX_QUADRANT_VERTICES];
	logic [QV_W-1:0]       step_rem [1:MAX_QUADRANT_VERTICES];

	for (genvar k = 1; k <= MAX_QUADRANT_VERTICES; k++) begin : g_step
		localparam int unsigned QUO = (1 << (ANGLE_BITS - 2)) / k;
		localparam int unsigned REM = (1 << (ANGLE_BITS - 2)) % k;
		assign step_quo[k] = ANGLE_BITS'(QUO);
		assign step_rem[k] = QV_W'(REM);
	end

	logic [QV_W-1:0]          n_eff;
	logic [VNUM_W-1:0]        four_n;
	logic                     last_v;
	logic [QV_W:0]            rem_sum;
	logic                     rem_carry;
	logic [QV_W-1:0]          rem_next;
	logic [ANGLE_BITS-1:0]    theta_next;
	logic                     fill_on;
	logic [SHADE_W-1:0]       sh_sel;
	logic signed [9:0]        color_span;
	logic signed [10:0]       ci_raw;
	logic signed [10:0]       lo_ext;
	logic signed [10:0]       hi_ext;
	logic [COLOR_W-1:0]       ci_clamped;
	logic [31:0]              in_angle;
	logic [31:0]              vert_angle;
	logic                     in_accept;
	logic signed [ACC_W-1:0]  bias_x;
	logic signed [ACC_W-1:0]  bias_y;

	cordic_req_t              cordic_req;
	cordic_rsp_t              cordic_rsp;
	mac_req_t                 mac_req;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (quad_q == '0) begin
			n_eff = QV_W'(1);
		end else if (quad_q > QV_W'(MAX_QUADRANT_VERTICES)) begin
			n_eff = QV_W'(MAX_QUADRANT_VERTICES);
		end else begin
			n_eff = quad_q;
		end
		four_n = {n_eff, 2'b00};
		last_v = (v_q == four_n);

		// theta tracks floor(v * quarter / N) as quotient plus remainder
		rem_sum    = {1'b0, rem_q} + {1'b0, step_rem[n_eff]};
		rem_carry  = (rem_sum >= {1'b0, n_eff});
		rem_next   = rem_carry ? QV_W'(rem_sum - {1'b0, n_eff}) : rem_sum[QV_W-1:0];
		theta_next = theta_q + step_quo[n_eff] + ANGLE_BITS'(rem_carry);

		fill_on    = (fill_mode_q == FILL_INPUT) || (fill_mode_q == FILL_CONST);
		sh_sel     = (fill_mode_q == FILL_INPUT) ? shade_q : fill_shade_q;
		color_span = $signed({2'b00, color_high_q}) - $signed({2'b00, color_low_q}) + 10'sd1;
		lo_ext     = $signed({3'b000, color_low_q});
		hi_ext     = $signed({3'b000, color_high_q});
		ci_raw     = lo_ext + $signed(prod_s1[TRIG_FRAC+10:TRIG_FRAC]);
		// the upper bound is tested first and wins where an inverted range puts a value past both bounds
		if (ci_raw > hi_ext) begin
			ci_clamped = color_high_q;
		end else if (ci_raw < lo_ext) begin
			ci_clamped = color_low_q;
		end else begin
			ci_clamped = ci_raw[COLOR_W-1:0];
		end

		in_angle   = {s_axis_tdata[143:128], 16'h0000} & ANGLE_MASK;
		vert_angle = {theta_q, {(32 - ANGLE_BITS){1'b0}}};

		// centre in Q16.16 shifted up to the product scale, plus the rounding half
		bias_x = $signed({{(ACC_W-COORD_W-TRIG_FRAC){cx_q[COORD_W-1]}}, cx_q,
			1'b1, {(TRIG_FRAC-1){1'b0}}});
		bias_y = $signed({{(ACC_W-COORD_W-TRIG_FRAC){cy_q[COORD_W-1]}}, cy_q,
			1'b1, {(TRIG_FRAC-1){1'b0}}});
	end

	always_comb begin
		cordic_req.start = in_accept || (state_q == S_V_START);
		cordic_req.angle = (state_q == S_IDLE) ? in_angle : vert_angle;
	end

	always_comb begin
		mac_req = '0;
		case (state_q)
			S_FILL_MUL: begin
				mac_req.op = MAC_MUL;
				mac_req.a  = $signed({{(TERM_W-SHADE_W){1'b0}}, sh_sel});
				mac_req.b  = TRIG_W'(color_span);
			end
			S_MUL_A: begin
				mac_req.op = MAC_MUL;
				mac_req.a  = TERM_W'(ax_q);
				mac_req.b  = cordic_rsp.cos_v;
			end
			S_MUL_B: begin
				mac_req.op = MAC_MUL;
				mac_req.a  = TERM_W'(bx_q);
				mac_req.b  = cordic_rsp.sin_v;
			end
			S_MUL_XC: begin
				mac_req.op   = MAC_LOAD;
				mac_req.a    = x_term_q;
				mac_req.b    = rot_cos_q;
				mac_req.bias = bias_x;
			end
			S_MUL_YS: begin
				mac_req.op = MAC_SUB;
				mac_req.a  = y_term_q;
				mac_req.b  = rot_sin_q;
			end
			S_MUL_XS: begin
				mac_req.op   = MAC_LOAD;
				mac_req.a    = x_term_q;
				mac_req.b    = rot_sin_q;
				mac_req.bias = bias_y;
			end
			S_MUL_YC: begin
				mac_req.op = MAC_ADD;
				mac_req.a  = y_term_q;
				mac_req.b  = rot_cos_q;
			end
			default: begin
				mac_req.op = MAC_NONE;
			end
		endcase
	end

	rev_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cordic_req),
		.rsp    (cordic_rsp)
	);

	rev_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mac_req),
		.prod_s1 (prod_s1),
		.acc_q   (acc_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_q         <= QV_W'(1);
			fill_mode_q    <= FILL_NONE;
			fill_shade_q   <= '0;
			color_low_q    <= '0;
			color_high_q   <= COLOR_W'(15);
			draw_outline_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUAD_VERTS: quad_q         <= cfg_data[QV_W-1:0];
				REG_FILL_MODE:  fill_mode_q    <= cfg_data[1:0];
				REG_FILL_SHADE: fill_shade_q   <= cfg_data[SHADE_W-1:0];
				REG_COLOR_LOW:  color_low_q    <= cfg_data[COLOR_W-1:0];
				REG_COLOR_HIGH: color_high_q   <= cfg_data[COLOR_W-1:0];
				REG_OUTLINE:    draw_outline_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cx_q           <= '0;
			cy_q           <= '0;
			ax_q           <= '0;
			bx_q           <= '0;
			shade_q        <= '0;
			final_q        <= 1'b0;
			rot_cos_q      <= '0;
			rot_sin_q      <= '0;
			fill_en_q      <= 1'b0;
			fill_idx_q     <= '0;
			theta_q        <= '0;
			rem_q          <= '0;
			v_q            <= '0;
			x_term_q       <= '0;
			y_term_q       <= '0;
			vx_q           <= '0;
			vy_q           <= '0;
			m_valid_q      <= 1'b0;
			out_x_q        <= '0;
			out_y_q        <= '0;
			out_num_q      <= '0;
			out_last_q     <= 1'b0;
			out_fill_en_q  <= 1'b0;
			out_fill_idx_q <= '0;
			out_outline_q  <= 1'b0;
			out_set_end_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						cx_q    <= $signed(s_axis_tdata[31:0]);
						cy_q    <= $signed(s_axis_tdata[63:32]);
						ax_q    <= $signed(s_axis_tdata[95:64]);
						bx_q    <= $signed(s_axis_tdata[127:96]);
						shade_q <= s_axis_tdata[159:144];
						final_q <= s_axis_tlast;
						theta_q <= '0;
						rem_q   <= '0;
						v_q     <= '0;
						state_q <= S_ROT_WAIT;
					end
				end
				S_ROT_WAIT: begin
					if (cordic_rsp.done) begin
						rot_cos_q <= cordic_rsp.cos_v;
						rot_sin_q <= cordic_rsp.sin_v;
						state_q   <= S_FILL_MUL;
					end
				end
				S_FILL_MUL: begin
					state_q <= S_FILL_IDX;
				end
				S_FILL_IDX: begin
					fill_en_q  <= fill_on;
					fill_idx_q <= fill_on ? ci_clamped : '0;
					state_q    <= S_V_START;
				end
				S_V_START: begin
					state_q <= S_V_WAIT;
				end
				S_V_WAIT: begin
					if (cordic_rsp.done) begin
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: begin
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					x_term_q <= rev_round_term(prod_s1);
					state_q  <= S_MUL_XC;
				end
				S_MUL_XC: begin
					y_term_q <= rev_round_term(prod_s1);
					state_q  <= S_MUL_YS;
				end
				S_MUL_YS: begin
					state_q <= S_MUL_XS;
				end
				S_MUL_XS: begin
					state_q <= S_MUL_YC;
				end
				S_MUL_YC: begin
					vx_q    <= rev_sat_coord(acc_q);
					state_q <= S_SUM_WAIT;
				end
				S_SUM_WAIT: begin
					state_q <= S_SUM_Y;
				end
				S_SUM_Y: begin
					vy_q    <= rev_sat_coord(acc_q);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold the vertex until the output register is free
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q      <= 1'b1;
						out_x_q        <= vx_q;
						out_y_q        <= vy_q;
						out_num_q      <= v_q;
						out_last_q     <= last_v;
						out_fill_en_q  <= fill_en_q;
						out_fill_idx_q <= fill_idx_q;
						out_outline_q  <= draw_outline_q;
						out_set_end_q  <= last_v && final_q;
						if (last_v) begin
							state_q <= S_IDLE;
						end else begin
							v_q     <= v_q + 1'b1;
							theta_q <= theta_next;
							rem_q   <= rem_next;
							state_q <= S_V_START;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, out_fill_idx_q, out_num_q, out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_set_end_q, out_outline_q, out_fill_en_q, out_last_q};

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("input ready stayed high after an ellipse was taken");

	a_set_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast && m_axis_tuser[0])
		else $error("set end flagged on a vertex that does not close the ellipse");

endmodule
